// ----- design/plba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package plba_pkg;

  // Field widths fixed by the request and response formats.
  localparam int unsigned DataW = 32;
  localparam int unsigned LinkW = 6;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CntW  = 6;

  // Default pool size handed to the top level.
  localparam int unsigned DefPoolSlots = 32;

  // A link value of 32 is the null link; as a link owner it names the list head.
  localparam logic [LinkW-1:0] NullLink = LinkW'(32);

  // Request types.
  localparam logic ReqAppend = 1'b0;
  localparam logic ReqRemove = 1'b1;

  // Response status codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [DataW-1:0] entry_key;
    logic [DataW-1:0] data_value;
    logic [LinkW-1:0] link_owner;
  } plba_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot_index;
    logic [DataW-1:0] value_out;
    logic [CntW-1:0]  entry_count;
  } plba_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LINK,
    S_RM_OWN,
    S_RM_VAL,
    S_RM_COMMIT,
    S_DONE
  } plba_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic do_append;
    logic do_link;
    logic rd_owner;
    logic set_tgt_head;
    logic load_tgt;
    logic rd_target;
    logic do_remove;
    logic set_err_full;
    logic set_err_empty;
    logic load_out;
  } plba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic full;
    logic count_zero;
    logic from_head;
    logic owner_bad;
    logic tgt_bad;
    logic tail_valid;
    logic out_free;
  } plba_sts_t;

endpackage

`default_nettype wire

// ----- design/plba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plba_ctrl
  import plba_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire plba_sts_t sts_i,
  output plba_cmd_t      cmd_o
);

  plba_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_remove) begin
          if (sts_i.full) begin
            cmd_o.set_err_full = 1'b1;
            state_d            = S_DONE;
          end else begin
            cmd_o.do_append = 1'b1;
            state_d         = sts_i.tail_valid ? S_LINK : S_DONE;
          end
        end else if (sts_i.count_zero) begin
          cmd_o.set_err_empty = 1'b1;
          state_d             = S_DONE;
        end else if (sts_i.from_head) begin
          cmd_o.set_tgt_head = 1'b1;
          state_d            = S_RM_VAL;
        end else if (sts_i.owner_bad) begin
          cmd_o.set_err_empty = 1'b1;
          state_d             = S_DONE;
        end else begin
          cmd_o.rd_owner = 1'b1;
          state_d        = S_RM_OWN;
        end
      end
      S_LINK: begin
        cmd_o.do_link = 1'b1;
        state_d       = S_DONE;
      end
      S_RM_OWN: begin
        cmd_o.load_tgt = 1'b1;
        state_d        = S_RM_VAL;
      end
      S_RM_VAL: begin
        if (sts_i.tgt_bad) begin
          cmd_o.set_err_empty = 1'b1;
          state_d             = S_DONE;
        end else begin
          cmd_o.rd_target = 1'b1;
          state_d         = S_RM_COMMIT;
        end
      end
      S_RM_COMMIT: begin
        cmd_o.do_remove = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/plba_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module plba_dp
  import plba_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DefPoolSlots
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire plba_req_t in_req_i,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output plba_rsp_t      out_rsp_o,
  input  wire plba_cmd_t cmd_i,
  output plba_sts_t      sts_o
);

  localparam int unsigned IdxW = $clog2(POOL_SLOTS);
  localparam logic [LinkW-1:0] PoolLimit = LinkW'(POOL_SLOTS);

  // Pool stores. Their contents are only meaningful for slots in the list.
  logic [DataW-1:0] key_mem   [POOL_SLOTS];
  logic [DataW-1:0] value_mem [POOL_SLOTS];
  logic [LinkW-1:0] next_mem  [POOL_SLOTS];

  logic [POOL_SLOTS-1:0] free_map_q;
  logic [LinkW-1:0]      head_q, tail_q;
  logic [CntW-1:0]       count_q;

  plba_req_t        req_q;
  logic [LinkW-1:0] tgt_q;
  logic [IdxW-1:0]  link_addr_q, new_slot_q;
  logic [LinkW-1:0] next_rd_q;
  logic [DataW-1:0] val_rd_q;
  plba_rsp_t        res_q, out_q;
  logic             out_valid_q;

  logic [IdxW-1:0]  alloc_idx;
  logic             from_head;
  logic [IdxW-1:0]  owner_idx, tgt_idx;
  logic             nx_we;
  logic [IdxW-1:0]  nx_wa, rd_addr;
  logic [LinkW-1:0] nx_wd;

  // Lowest free slot.
  always_comb begin
    alloc_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (free_map_q[i]) begin
        alloc_idx = IdxW'(i);
      end
    end
  end

  assign from_head = (req_q.link_owner == NullLink);
  assign owner_idx = req_q.link_owner[IdxW-1:0];
  assign tgt_idx   = tgt_q[IdxW-1:0];

  assign sts_o.is_remove  = (req_q.req_type == ReqRemove);
  assign sts_o.full       = ~|free_map_q;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.from_head  = from_head;
  assign sts_o.owner_bad  = (req_q.link_owner >= PoolLimit) || free_map_q[owner_idx];
  assign sts_o.tgt_bad    = (tgt_q >= PoolLimit) || free_map_q[tgt_idx];
  assign sts_o.tail_valid = (tail_q != NullLink);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Single write port on the link store.
  always_comb begin
    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = NullLink;
    if (cmd_i.do_append) begin
      nx_we = 1'b1;
      nx_wa = alloc_idx;
    end else if (cmd_i.do_link) begin
      nx_we = 1'b1;
      nx_wa = link_addr_q;
      nx_wd = LinkW'(new_slot_q);
    end else if (cmd_i.do_remove && !from_head) begin
      nx_we = 1'b1;
      nx_wa = owner_idx;
      nx_wd = next_rd_q;
    end
  end

  assign rd_addr = cmd_i.rd_owner ? owner_idx : tgt_idx;

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (cmd_i.do_append) begin
      key_mem[alloc_idx]   <= req_q.entry_key;
      value_mem[alloc_idx] <= req_q.data_value;
    end
    if (cmd_i.rd_owner || cmd_i.rd_target) begin
      next_rd_q <= next_mem[rd_addr];
    end
    if (cmd_i.rd_target) begin
      val_rd_q <= value_mem[tgt_idx];
    end
  end

  // List control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_map_q <= '1;
      head_q     <= NullLink;
      tail_q     <= NullLink;
      count_q    <= '0;
    end else if (cmd_i.do_append) begin
      free_map_q[alloc_idx] <= 1'b0;
      if (tail_q == NullLink) begin
        head_q <= LinkW'(alloc_idx);
      end
      tail_q  <= LinkW'(alloc_idx);
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.do_remove) begin
      free_map_q[tgt_idx] <= 1'b1;
      if (from_head) begin
        head_q <= next_rd_q;
      end
      if (tail_q == tgt_q) begin
        tail_q <= from_head ? NullLink : req_q.link_owner;
      end
      count_q <= count_q - CntW'(1);
    end
  end

  // Request, target and pending response registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.set_tgt_head) begin
      tgt_q <= head_q;
    end else if (cmd_i.load_tgt) begin
      tgt_q <= next_rd_q;
    end
    if (cmd_i.do_append) begin
      link_addr_q       <= tail_q[IdxW-1:0];
      new_slot_q        <= alloc_idx;
      res_q.status      <= StOk;
      res_q.slot_index  <= SlotW'(alloc_idx);
      res_q.value_out   <= '0;
      res_q.entry_count <= count_q + CntW'(1);
    end else if (cmd_i.do_remove) begin
      res_q.status      <= StOk;
      res_q.slot_index  <= SlotW'(tgt_idx);
      res_q.value_out   <= val_rd_q;
      res_q.entry_count <= count_q - CntW'(1);
    end else if (cmd_i.set_err_full || cmd_i.set_err_empty) begin
      res_q.status      <= cmd_i.set_err_full ? StFull : StEmpty;
      res_q.slot_index  <= '0;
      res_q.value_out   <= '0;
      res_q.entry_count <= count_q;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  // Every slot is either free or holds exactly one list entry.
  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) + 32'($countones(free_map_q))) == 32'(POOL_SLOTS))
    else $error("entry count disagrees with free map");

  a_head_null_iff_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == NullLink))
    else $error("head link inconsistent with entry count");

  a_tail_null_iff_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (tail_q == NullLink))
    else $error("tail slot inconsistent with entry count");

  a_load_out_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("response overwrote an untaken response");
`endif

endmodule

`default_nettype wire

// ----- design/pooled_list_bitmap_allocator.sv -----
// Pooled linked-list allocator: keeps a singly linked list of key/value entries in a pool
// of POOL_SLOTS slots, with a free-slot bitmap in which a 1 marks a free slot. An append
// request takes the lowest free slot, stores key and value there and links it at the tail
// (status 1 when the pool is full); a remove request cuts the head link (link_owner 32)
// or the next link of a given slot, frees the node behind it and returns its value
// (status 2 when the list is empty, the owner is out of range or free, or the link is
// null). Every request yields exactly one response carrying the entry count afterwards.
// Requests are handled one at a time: the controller steps each through decode, any link
// lookups, a relink or commit state and a done state before the next one is accepted.
// This sequence is set by the link store, which has one write port and a registered read,
// so relinking and every link lookup get a state of their own. A finished response sits
// in an output register, so the next request is accepted while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module pooled_list_bitmap_allocator
  import plba_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DefPoolSlots
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // Request channel.
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire plba_req_t in_req_i,
  // Response channel.
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output plba_rsp_t      out_rsp_o
);

  // The controller sequences each request through decode, link lookups and commit;
  // the datapath holds the pool stores, the free map, head, tail and count.
  plba_cmd_t cmd;
  plba_sts_t sts;

  plba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plba_dp #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

// ----- sim/plba_list_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the allocator, tracks the list and the free map
// on its own, and compares every response against the oldest prediction.
module plba_list_checker
  import plba_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = DefPoolSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  plba_req_t   req_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_stall_i,
  input  plba_rsp_t   rsp_i,
  output int unsigned fail_count_o,
  output int unsigned open_rsps_o
);

  // Shadow of the pool. Keys are never read back by the block, so none are kept.
  logic [31:0]       free_bits;
  logic [DataW-1:0]  val_mem  [0:31];
  logic [LinkW-1:0]  link_mem [0:31];
  logic [LinkW-1:0]  list_head;
  logic [LinkW-1:0]  list_tail;
  logic [CntW-1:0]   live_cnt;
  plba_rsp_t         predicted_rsps [$];

  task automatic clear_pool();
    free_bits = '1;
    for (int i = 0; i < 32; i++) begin
      val_mem[i]  = '0;
      link_mem[i] = NullLink;
    end
    list_head = NullLink;
    list_tail = NullLink;
    live_cnt  = '0;
  endtask

  // Applies one request to the shadow pool and returns the response it should give.
  task automatic apply_list_op(input plba_req_t rq, output plba_rsp_t rs);
    logic [LinkW-1:0] tgt;
    logic [LinkW-1:0] nxt;
    logic             from_head;
    int unsigned      slot;
    rs        = '0;
    rs.status = StOk;
    tgt       = NullLink;
    if (rq.req_type == ReqAppend) begin
      slot = POOL_SLOTS;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
        if (free_bits[i]) slot = i;
      end
      if (live_cnt >= POOL_SLOTS || slot >= POOL_SLOTS) begin
        rs.status = StFull;
      end else begin
        free_bits[slot] = 1'b0;
        val_mem[slot]   = rq.data_value;
        link_mem[slot]  = NullLink;
        if (list_tail == NullLink) begin
          list_head = LinkW'(slot);
        end else begin
          link_mem[list_tail[4:0]] = LinkW'(slot);
        end
        list_tail     = LinkW'(slot);
        live_cnt      = live_cnt + 1'b1;
        rs.slot_index = SlotW'(slot);
      end
    end else begin
      from_head = (rq.link_owner == NullLink);
      if (live_cnt == 0) begin
        rs.status = StEmpty;
      end else if (from_head) begin
        tgt = list_head;
      end else if (rq.link_owner >= POOL_SLOTS || free_bits[rq.link_owner[4:0]]) begin
        rs.status = StEmpty;
      end else begin
        tgt = link_mem[rq.link_owner[4:0]];
      end
      if (rs.status == StOk && (tgt >= POOL_SLOTS || free_bits[tgt[4:0]])) begin
        rs.status = StEmpty;
      end
      if (rs.status == StOk) begin
        nxt = link_mem[tgt[4:0]];
        if (from_head) begin
          list_head = nxt;
        end else begin
          link_mem[rq.link_owner[4:0]] = nxt;
        end
        if (list_tail == tgt) begin
          list_tail = from_head ? NullLink : rq.link_owner;
        end
        free_bits[tgt[4:0]] = 1'b1;
        link_mem[tgt[4:0]]  = NullLink;
        live_cnt            = live_cnt - 1'b1;
        rs.slot_index       = tgt[4:0];
        rs.value_out        = val_mem[tgt[4:0]];
      end
    end
    rs.entry_count = live_cnt;
  endtask

  // A response taken at an edge always stems from an earlier request, so the
  // comparison runs before the request of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    plba_rsp_t want;
    if (!rst_ni) begin
      clear_pool();
      predicted_rsps.delete();
      open_rsps_o  = 0;
      fail_count_o = 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (predicted_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp_i);
          fail_count_o++;
        end else begin
          want = predicted_rsps.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            fail_count_o++;
          end
          if (rsp_i.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_i.slot_index);
            fail_count_o++;
          end
          if (rsp_i.value_out !== want.value_out) begin
            $error("value_out: expected 0x%08h, got 0x%08h", want.value_out, rsp_i.value_out);
            fail_count_o++;
          end
          if (rsp_i.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp_i.entry_count);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        apply_list_op(req_i, want);
        predicted_rsps.push_back(want);
      end
      open_rsps_o = predicted_rsps.size();
    end
  end

endmodule

// ----- sim/pooled_list_bitmap_allocator_tb.sv -----
`timescale 1ns / 1ps

// Top of the allocator testbench. It generates the clock and the reset, drives
// requests, applies random stalls on the response side and reports the verdict.
// All prediction and comparison happen in the checker instantiated below.
module pooled_list_bitmap_allocator_tb;
  import plba_pkg::*;

  localparam int unsigned PoolSlots  = DefPoolSlots;
  localparam int unsigned RandomReqs = 1400;
  // Even with the longest sender gap and the longest response stall on every
  // request the run stays far below this limit.
  localparam int unsigned CycleLimit = 400000;

  // Request mix of a stretch of random traffic: filling drives the pool into the
  // full case, draining walks the list down to empty, mixed traffic sits between.
  typedef enum int {
    BurstMix,
    BurstFill,
    BurstDrain
  } burst_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  plba_req_t   in_req;
  logic        out_valid;
  logic        out_stall;
  plba_rsp_t   out_rsp;
  int unsigned fail_count;
  int unsigned open_rsps;
  int unsigned cycle_cnt;

  pooled_list_bitmap_allocator #(
    .POOL_SLOTS(PoolSlots)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  plba_list_checker #(
    .POOL_SLOTS(PoolSlots)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (in_valid),
    .req_stall_i (in_stall),
    .req_i       (in_req),
    .rsp_valid_i (out_valid),
    .rsp_stall_i (out_stall),
    .rsp_i       (out_rsp),
    .fail_count_o(fail_count),
    .open_rsps_o (open_rsps)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // A hung handshake or a missing response ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("pooled_list_bitmap_allocator test failed");
      $finish;
    end
  end

  // An append carries a random link owner, since the block must ignore it.
  function automatic plba_req_t append_req(input logic [DataW-1:0] key,
                                           input logic [DataW-1:0] val);
    plba_req_t rq;
    rq.req_type   = ReqAppend;
    rq.entry_key  = key;
    rq.data_value = val;
    rq.link_owner = LinkW'($urandom_range(0, 63));
    return rq;
  endfunction

  // A remove carries random key and value words, which must be ignored as well.
  function automatic plba_req_t remove_req(input logic [LinkW-1:0] owner);
    plba_req_t rq;
    rq.req_type   = ReqRemove;
    rq.entry_key  = $urandom;
    rq.data_value = $urandom;
    rq.link_owner = owner;
    return rq;
  endfunction

  // Slots are handed out lowest first, so live entries crowd the low indices.
  // Owners are drawn most often from a random low range to hit live, linked slots;
  // the rest are the head, any slot, or an owner beyond the pool.
  function automatic logic [LinkW-1:0] pick_owner();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return NullLink;
    if (roll < 80) return LinkW'($urandom_range(0, $urandom_range(1, PoolSlots - 1)));
    if (roll < 92) return LinkW'($urandom_range(0, 31));
    return LinkW'($urandom_range(33, 63));
  endfunction

  function automatic plba_req_t random_req(input burst_mode_e mode);
    int unsigned append_pct;
    case (mode)
      BurstFill:  append_pct = 85;
      BurstDrain: append_pct = 15;
      default:    append_pct = 50;
    endcase
    if ($urandom_range(0, 99) < append_pct) return append_req($urandom, $urandom);
    return remove_req(pick_owner());
  endfunction

  // Idle cycles before a request: mostly none or a few, now and then a long gap.
  function automatic int unsigned pick_gap(input bit no_gaps);
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Inputs change only at the falling edge. Valid stays high from one request to
  // the next when there is no gap, and the payload holds while the block stalls.
  task automatic send_req(input plba_req_t rq, input bit no_gaps);
    int unsigned gap;
    gap = pick_gap(no_gaps);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = rq;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Response-side stalls: short holds most of the time, a few long ones, and
  // calm stretches with no stall at all.
  initial begin : rsp_backpressure
    int unsigned hold;
    int unsigned calm;
    hold      = 0;
    calm      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        if (calm != 0) begin
          calm--;
        end else if ($urandom_range(0, 99) < 3) begin
          calm = $urandom_range(20, 80);
        end else if ($urandom_range(0, 99) < 25) begin
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst_len;
    bit          no_gaps;
    burst_mode_e mode;
    cycle_cnt = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Removes on an empty list, through the head and through a slot.
    send_req(remove_req(NullLink), 1'b0);
    send_req(remove_req(LinkW'(5)), 1'b0);
    // Field extremes and the marker patterns fill slots 0 to 3 in order.
    send_req(append_req(32'h0000_0000, 32'h0000_0000), 1'b0);
    send_req(append_req(32'hffff_ffff, 32'hffff_ffff), 1'b0);
    send_req(append_req(32'h0000_00ff, 32'h0000_ff00), 1'b0);
    send_req(append_req(32'h0000_ff00, 32'h0000_00ff), 1'b0);
    // Owners outside the pool, and an owner slot that is free.
    send_req(remove_req(LinkW'(33)), 1'b0);
    send_req(remove_req(LinkW'(63)), 1'b0);
    send_req(remove_req(LinkW'(20)), 1'b0);
    // The tail's next link is null, so cutting it must fail.
    send_req(remove_req(LinkW'(3)), 1'b0);
    // Removing the tail through slot 2 makes slot 2 the tail; the next append
    // must then link behind it and reuse slot 3.
    send_req(remove_req(LinkW'(2)), 1'b0);
    send_req(append_req($urandom, $urandom), 1'b0);
    // A node from the middle of the list, then everything through the head until
    // the list runs empty and the tail falls back to null.
    send_req(remove_req(LinkW'(0)), 1'b0);
    send_req(remove_req(NullLink), 1'b0);
    send_req(remove_req(NullLink), 1'b0);
    send_req(remove_req(NullLink), 1'b0);
    send_req(remove_req(NullLink), 1'b0);
    // A fresh head on an empty list, its null link, and its removal through the head.
    send_req(append_req($urandom, $urandom), 1'b0);
    send_req(remove_req(LinkW'(0)), 1'b0);
    send_req(remove_req(NullLink), 1'b0);
    send_req(append_req($urandom, $urandom), 1'b1);
    send_req(append_req($urandom, $urandom), 1'b1);

    // Hold off until the block has answered everything sent so far.
    in_valid = 1'b0;
    wait (open_rsps == 0);
    @(negedge clk);

    // Random part in bursts of one mix each; some bursts run back to back with
    // no gaps, and some start only once every response has come back.
    sent = 0;
    while (sent < RandomReqs) begin
      case ($urandom_range(0, 2))
        0:       mode = BurstFill;
        1:       mode = BurstDrain;
        default: mode = BurstMix;
      endcase
      no_gaps   = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(15, 60);
      if ($urandom_range(0, 9) == 0) begin
        in_valid = 1'b0;
        wait (open_rsps == 0);
        @(negedge clk);
      end
      repeat (burst_len) begin
        if (sent < RandomReqs) begin
          send_req(random_req(mode), no_gaps);
          sent++;
        end
      end
    end
    in_valid = 1'b0;

    // Drain, then leave time for any response that should not be there.
    wait (open_rsps == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && open_rsps == 0) begin
      $display("pooled_list_bitmap_allocator test passed");
    end else begin
      $display("pooled_list_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule
